// ----- rtl/mark_sweep_slab_allocator_core_macros.svh -----
// Assertion macros shared by the slab allocator RTL.
`ifndef MARK_SWEEP_SLAB_ALLOCATOR_CORE_MACROS_SVH
`define MARK_SWEEP_SLAB_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset
`define MSA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset
`define MSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/msa_pkg.sv -----
// Types and codes of the mark-sweep slab allocator.
package msa_pkg;

   // Commands
   localparam logic [2:0] CMD_ALLOC = 3'd0;
   localparam logic [2:0] CMD_FREE  = 3'd1;
   localparam logic [2:0] CMD_MARK  = 3'd2;
   localparam logic [2:0] CMD_START = 3'd3;
   localparam logic [2:0] CMD_SWEEP = 3'd4;

   // Status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_FULL       = 2'd1;
   localparam logic [1:0] ST_RANGE      = 2'd2;
   localparam logic [1:0] ST_DOUBLE_FREE = 2'd3;

   // Bit positions in a slot's flag word
   localparam int FLAG_MARK = 0;
   localparam int FLAG_FREE = 1;

   localparam logic [10:0] CAPACITY_RESET = 11'd1024;

   typedef struct packed {
      logic [2:0] command;
      logic [9:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  result_slot;
      logic        newly_marked;
      logic [10:0] live_count;
      logic [10:0] free_count;
      logic [10:0] avail_count;
      logic        slab_released;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_WALK = 4'b0100,
      S_RESP = 4'b1000
   } state_type;

   // What a walk over the slots does
   typedef enum logic [1:0] {
      WALK_INIT   = 2'd0,
      WALK_WIPE   = 2'd1,
      WALK_UNMARK = 2'd2,
      WALK_SWEEP  = 2'd3
   } walk_type;

endpackage

// ----- rtl/msa_ram.sv -----
// Generic simple dual-port RAM with registered read.
module msa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/mark_sweep_slab_allocator_core.sv -----
// Mark-sweep slab allocator: free list, mark and free bitmaps, sweep engine.
//
// Each transaction on req carries one command and yields one transaction on
// rsp. Alloc, free, mark and unknown commands read the slot's flag word and
// free-list link from RAM in the idle state and update them in the execute
// state; a stalled rsp holds the command there. Start_collect and sweep walk
// the slots below the high-water count through the flag RAM, one slot per
// cycle, and then respond; a sweep that finds no marks wipes the same range.
// After reset a clearing pass over all CAPACITY flag entries runs with
// req_stall high; csr writes are taken at any time.
module mark_sweep_slab_allocator_core #(
   parameter int CAPACITY = 1024
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  msa_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output msa_pkg::rsp_type rsp_data,
   input  logic            csr_wr_en,
   input  logic [10:0]     csr_wr_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int W     = (CNT_W > 11) ? CNT_W : 11;
   localparam logic [CNT_W-1:0] NULL_SLOT = CNT_W'(CAPACITY);

   // Control and count registers
   msa_pkg::state_type state_ff, state_in;
   msa_pkg::walk_type  mode_ff, mode_in;
   logic [10:0]      capacity_ff, capacity_in;
   logic [CNT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] hw_ff, hw_in;
   logic [CNT_W-1:0] free_total_ff, free_total_in;
   logic [CNT_W-1:0] marked_ff, marked_in;
   logic             collecting_ff, collecting_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] limit_ff, limit_in;
   logic             p1_ff, p1_in;
   logic [IDX_W-1:0] pa_ff, pa_in;
   msa_pkg::req_type req_ff, req_in;
   logic             rsp_valid_ff, rsp_valid_in;
   msa_pkg::rsp_type rsp_ff, rsp_in;

   // RAM ports
   logic             fl_wr_en;
   logic [IDX_W-1:0] fl_wr_addr, fl_rd_addr;
   logic [1:0]       fl_wr_data, fl_rd_data;
   logic             nf_wr_en;
   logic [IDX_W-1:0] nf_wr_addr;
   logic [IDX_W-1:0] nf_wr_data, nf_rd_data;

   // Derived values
   logic [W-1:0]     cap_w, hw_w, slot_w;
   logic [2:0]       cmd_w;
   logic             list_ne, can_bump, req_accept, rsp_free;
   logic [CNT_W-1:0] alloc_slot;

   assign cap_w    = (W'(capacity_ff) > W'(CAPACITY)) ? W'(CAPACITY) : W'(capacity_ff);
   assign hw_w     = W'(hw_ff);
   assign list_ne  = (head_ff < NULL_SLOT) && (free_total_ff != '0);
   assign can_bump = hw_w < cap_w;
   assign alloc_slot = list_ne ? head_ff : hw_ff;

   assign req_stall  = (state_ff != msa_pkg::S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign slot_w     = (state_ff == msa_pkg::S_IDLE) ? W'(req_data.slot_index)
                                                     : W'(req_ff.slot_index);
   assign cmd_w      = (state_ff == msa_pkg::S_IDLE) ? req_data.command
                                                     : req_ff.command;

   // Read addresses: walk index, or the slot the pending command touches
   always_comb begin
      if (state_ff == msa_pkg::S_WALK) begin
         fl_rd_addr = idx_ff[IDX_W-1:0];
      end else if (cmd_w == msa_pkg::CMD_ALLOC) begin
         fl_rd_addr = alloc_slot[IDX_W-1:0];
      end else begin
         fl_rd_addr = slot_w[IDX_W-1:0];
      end
   end

   // Main control
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      capacity_in   = csr_wr_en ? csr_wr_data : capacity_ff;
      head_in       = head_ff;
      hw_in         = hw_ff;
      free_total_in = free_total_ff;
      marked_in     = marked_ff;
      collecting_in = collecting_ff;
      idx_in        = idx_ff;
      limit_in      = limit_ff;
      p1_in         = 1'b0;
      pa_in         = pa_ff;
      req_in        = req_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      fl_wr_en      = 1'b0;
      fl_wr_addr    = pa_ff;
      fl_wr_data    = '0;
      nf_wr_en      = 1'b0;
      nf_wr_addr    = pa_ff;
      nf_wr_data    = head_ff[IDX_W-1:0];

      unique case (state_ff)
         msa_pkg::S_IDLE: begin
            if (req_accept) begin
               req_in   = req_data;
               state_in = msa_pkg::S_EXEC;
            end
         end

         msa_pkg::S_EXEC: begin
            if (rsp_free) begin
               rsp_in = '0;
               state_in = msa_pkg::S_IDLE;
               unique case (req_ff.command)
                  msa_pkg::CMD_ALLOC: begin
                     if (list_ne || can_bump) begin
                        fl_wr_en   = 1'b1;
                        fl_wr_addr = alloc_slot[IDX_W-1:0];
                        fl_wr_data[msa_pkg::FLAG_FREE] = 1'b0;
                        fl_wr_data[msa_pkg::FLAG_MARK] =
                           fl_rd_data[msa_pkg::FLAG_MARK] | collecting_ff;
                        if (collecting_ff && !fl_rd_data[msa_pkg::FLAG_MARK]) begin
                           marked_in = marked_ff + 1'b1;
                        end
                        rsp_in.result_slot = 10'(alloc_slot);
                        if (list_ne) begin
                           head_in       = CNT_W'(nf_rd_data);
                           free_total_in = free_total_ff - 1'b1;
                        end else begin
                           hw_in = hw_ff + 1'b1;
                        end
                     end else begin
                        rsp_in.status = msa_pkg::ST_FULL;
                     end
                  end
                  msa_pkg::CMD_FREE: begin
                     if (slot_w >= hw_w) begin
                        rsp_in.status = msa_pkg::ST_RANGE;
                     end else if (fl_rd_data[msa_pkg::FLAG_FREE]) begin
                        rsp_in.status = msa_pkg::ST_DOUBLE_FREE;
                     end else begin
                        fl_wr_en   = 1'b1;
                        fl_wr_addr = slot_w[IDX_W-1:0];
                        fl_wr_data = fl_rd_data | 2'(1 << msa_pkg::FLAG_FREE);
                        nf_wr_en   = 1'b1;
                        nf_wr_addr = slot_w[IDX_W-1:0];
                        head_in       = slot_w[CNT_W-1:0];
                        free_total_in = free_total_ff + 1'b1;
                     end
                  end
                  msa_pkg::CMD_MARK: begin
                     if (slot_w >= hw_w) begin
                        rsp_in.status = msa_pkg::ST_RANGE;
                     end else if (!fl_rd_data[msa_pkg::FLAG_MARK]) begin
                        fl_wr_en   = 1'b1;
                        fl_wr_addr = slot_w[IDX_W-1:0];
                        fl_wr_data = fl_rd_data | 2'(1 << msa_pkg::FLAG_MARK);
                        marked_in  = marked_ff + 1'b1;
                        rsp_in.newly_marked = 1'b1;
                     end
                  end
                  msa_pkg::CMD_START: begin
                     marked_in     = '0;
                     collecting_in = 1'b1;
                     mode_in       = msa_pkg::WALK_UNMARK;
                     idx_in        = '0;
                     limit_in      = hw_ff;
                     state_in      = msa_pkg::S_WALK;
                  end
                  msa_pkg::CMD_SWEEP: begin
                     idx_in        = '0;
                     limit_in      = hw_ff;
                     collecting_in = 1'b0;
                     state_in      = msa_pkg::S_WALK;
                     if (marked_ff == '0) begin
                        // Nothing reachable: release the whole slab
                        mode_in       = msa_pkg::WALK_WIPE;
                        head_in       = NULL_SLOT;
                        hw_in         = '0;
                        free_total_in = '0;
                     end else begin
                        mode_in = msa_pkg::WALK_SWEEP;
                     end
                  end
                  default: begin
                  end
               endcase
               if (state_in == msa_pkg::S_IDLE) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end

         msa_pkg::S_WALK: begin
            // Issue stage
            if (idx_ff < limit_ff) begin
               idx_in = idx_ff + 1'b1;
               pa_in  = idx_ff[IDX_W-1:0];
               if (mode_ff == msa_pkg::WALK_INIT || mode_ff == msa_pkg::WALK_WIPE) begin
                  fl_wr_en   = 1'b1;
                  fl_wr_addr = idx_ff[IDX_W-1:0];
                  fl_wr_data = '0;
               end else begin
                  p1_in = 1'b1;
               end
            end
            // Update stage, one slot behind
            if (p1_ff) begin
               if (mode_ff == msa_pkg::WALK_UNMARK) begin
                  fl_wr_en   = 1'b1;
                  fl_wr_data = fl_rd_data & ~2'(1 << msa_pkg::FLAG_MARK);
               end else if (!fl_rd_data[msa_pkg::FLAG_MARK] &&
                            !fl_rd_data[msa_pkg::FLAG_FREE]) begin
                  fl_wr_en      = 1'b1;
                  fl_wr_data    = fl_rd_data | 2'(1 << msa_pkg::FLAG_FREE);
                  nf_wr_en      = 1'b1;
                  head_in       = CNT_W'(pa_ff);
                  free_total_in = free_total_ff + 1'b1;
               end
            end
            if (idx_ff == limit_ff && !p1_ff) begin
               state_in = (mode_ff == msa_pkg::WALK_INIT) ? msa_pkg::S_IDLE
                                                          : msa_pkg::S_RESP;
            end
         end

         msa_pkg::S_RESP: begin
            if (rsp_free) begin
               rsp_in = '0;
               rsp_in.slab_released = (mode_ff == msa_pkg::WALK_WIPE);
               rsp_valid_in = 1'b1;
               state_in     = msa_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = msa_pkg::S_IDLE;
         end
      endcase

      // Counts reflect the state after the command
      if (rsp_valid_in && !(rsp_valid_ff && rsp_stall)) begin
         rsp_in.live_count  = 11'(hw_in - free_total_in);
         rsp_in.free_count  = 11'(free_total_in);
         rsp_in.avail_count = 11'(((cap_w > W'(hw_in)) ? (cap_w - W'(hw_in)) : W'(0))
                                  + W'(free_total_in));
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= msa_pkg::S_WALK;
         mode_ff       <= msa_pkg::WALK_INIT;
         capacity_ff   <= msa_pkg::CAPACITY_RESET;
         head_ff       <= NULL_SLOT;
         hw_ff         <= '0;
         free_total_ff <= '0;
         marked_ff     <= '0;
         collecting_ff <= 1'b0;
         idx_ff        <= '0;
         limit_ff      <= NULL_SLOT;
         p1_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         capacity_ff   <= capacity_in;
         head_ff       <= head_in;
         hw_ff         <= hw_in;
         free_total_ff <= free_total_in;
         marked_ff     <= marked_in;
         collecting_ff <= collecting_in;
         idx_ff        <= idx_in;
         limit_ff      <= limit_in;
         p1_ff         <= p1_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pa_ff  <= pa_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Free and mark flags per slot
   msa_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_flag_ram (
      .clock   (clock),
      .wr_en   (fl_wr_en),
      .wr_addr (fl_wr_addr),
      .wr_data (fl_wr_data),
      .rd_addr (fl_rd_addr),
      .rd_data (fl_rd_data)
   );

   // Free-list links
   msa_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_link_ram (
      .clock   (clock),
      .wr_en   (nf_wr_en),
      .wr_addr (nf_wr_addr),
      .wr_data (nf_wr_data),
      .rd_addr (head_ff[IDX_W-1:0]),
      .rd_data (nf_rd_data)
   );

   // Checks
`include "mark_sweep_slab_allocator_core_macros.svh"

   `MSA_ASSERT_NOW(a_free_le_hw, clock, reset, 1'b1, free_total_ff <= hw_ff,
                   "free count above high water")
   `MSA_ASSERT_NOW(a_marked_le_hw, clock, reset, 1'b1, marked_ff <= hw_ff,
                   "mark count above high water")
   `MSA_ASSERT_NOW(a_walk_bound, clock, reset, state_ff == msa_pkg::S_WALK,
                   idx_ff <= limit_ff, "walk index past its limit")
   `MSA_ASSERT_NEXT(a_accept_exec, clock, reset, req_accept,
                    state_ff == msa_pkg::S_EXEC, "accepted command not executed")

endmodule

// ----- tb/mark_sweep_slab_allocator_checker.sv -----
// Checker for the slab allocator: predicts each response and compares it.
`timescale 1ns / 100ps

module mark_sweep_slab_allocator_checker #(
   parameter int CAPACITY = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  msa_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  msa_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [10:0]      csr_wr_data,
   output int               fail_count,
   output int               pending_count
);

   // Shadow state of the slab
   logic [9:0]  link_mem [CAPACITY];
   logic        is_free [CAPACITY];
   logic        is_marked [CAPACITY];
   int unsigned head_slot;
   int unsigned hwm;
   int unsigned marks;
   int unsigned live;
   int unsigned on_list;
   bit          in_collect;
   int unsigned slab_cap;

   msa_pkg::rsp_type expected_rsp_q[$];

   assign pending_count = expected_rsp_q.size();

   function automatic void wipe_slab();
      for (int i = 0; i < CAPACITY; i++) begin
         link_mem[i] = '0;
         is_free[i] = 1'b0;
         is_marked[i] = 1'b0;
      end
      head_slot = CAPACITY;
      hwm = 0;
      marks = 0;
      live = 0;
      on_list = 0;
      in_collect = 1'b0;
   endfunction

   function automatic void push_free(int unsigned s);
      is_free[s] = 1'b1;
      link_mem[s] = head_slot[9:0];
      head_slot = s;
      on_list++;
   endfunction

   // Next-state and response for one command
   function automatic msa_pkg::rsp_type predict_slab_op(msa_pkg::req_type rq);
      msa_pkg::rsp_type r;
      int unsigned eff;
      int unsigned s;
      int unsigned got;
      int unsigned spare;
      r = '0;
      eff = (slab_cap > CAPACITY) ? CAPACITY : slab_cap;
      s = rq.slot_index;
      unique case (rq.command)
         msa_pkg::CMD_ALLOC: begin
            got = CAPACITY;
            if (head_slot < CAPACITY && on_list > 0) begin
               got = head_slot;
               head_slot = link_mem[got];
               is_free[got] = 1'b0;
               on_list--;
            end else if (hwm < eff) begin
               got = hwm;
               hwm++;
            end else begin
               r.status = msa_pkg::ST_FULL;
            end
            if (got < CAPACITY) begin
               r.result_slot = got[9:0];
               live = hwm - on_list;
               if (in_collect && !is_marked[got]) begin
                  is_marked[got] = 1'b1;
                  marks++;
               end
            end
         end
         msa_pkg::CMD_FREE: begin
            if (s >= hwm) r.status = msa_pkg::ST_RANGE;
            else if (is_free[s]) r.status = msa_pkg::ST_DOUBLE_FREE;
            else begin
               push_free(s);
               live = hwm - on_list;
            end
         end
         msa_pkg::CMD_MARK: begin
            if (s >= hwm) r.status = msa_pkg::ST_RANGE;
            else if (!is_marked[s]) begin
               is_marked[s] = 1'b1;
               marks++;
               r.newly_marked = 1'b1;
            end
         end
         msa_pkg::CMD_START: begin
            for (int i = 0; i < CAPACITY; i++) is_marked[i] = 1'b0;
            marks = 0;
            in_collect = 1'b1;
         end
         msa_pkg::CMD_SWEEP: begin
            if (marks == 0) begin
               wipe_slab();
               r.slab_released = 1'b1;
            end else begin
               for (int i = 0; i < int'(hwm); i++)
                  if (!is_marked[i] && !is_free[i]) push_free(i);
               live = hwm - on_list;
               in_collect = 1'b0;
            end
         end
         default: ;
      endcase
      spare = ((eff > hwm) ? eff - hwm : 0) + on_list;
      r.live_count = live[10:0];
      r.free_count = on_list[10:0];
      r.avail_count = spare[10:0];
      return r;
   endfunction

   // Watch both channels and the register port
   always @(posedge clock) begin
      msa_pkg::rsp_type want;
      if (reset) begin
         wipe_slab();
         slab_cap = msa_pkg::CAPACITY_RESET;
         expected_rsp_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_wr_en) slab_cap = csr_wr_data;
         if (req_valid && !req_stall)
            expected_rsp_q.push_back(predict_slab_op(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $error("unexpected response transaction");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsp_q.pop_front();
               if (want !== rsp_data) begin
                  if (want.status !== rsp_data.status)
                     $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  if (want.result_slot !== rsp_data.result_slot)
                     $error("result_slot: expected %0d, got %0d",
                            want.result_slot, rsp_data.result_slot);
                  if (want.newly_marked !== rsp_data.newly_marked)
                     $error("newly_marked: expected %0d, got %0d",
                            want.newly_marked, rsp_data.newly_marked);
                  if (want.live_count !== rsp_data.live_count)
                     $error("live_count: expected %0d, got %0d",
                            want.live_count, rsp_data.live_count);
                  if (want.free_count !== rsp_data.free_count)
                     $error("free_count: expected %0d, got %0d",
                            want.free_count, rsp_data.free_count);
                  if (want.avail_count !== rsp_data.avail_count)
                     $error("avail_count: expected %0d, got %0d",
                            want.avail_count, rsp_data.avail_count);
                  if (want.slab_released !== rsp_data.slab_released)
                     $error("slab_released: expected %0d, got %0d",
                            want.slab_released, rsp_data.slab_released);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ----- tb/tb_mark_sweep_slab_allocator_core.sv -----
// Testbench top for the slab allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_mark_sweep_slab_allocator_core;

   localparam int CAPACITY = 1024;
   localparam int CYCLE_LIMIT = 2000000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   msa_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   msa_pkg::rsp_type rsp_data;
   logic             csr_wr_en;
   logic [10:0]      csr_wr_data;
   int               fail_count;
   int               pending_count;
   int               cycle_count;
   bit               hold_rsp;

   mark_sweep_slab_allocator_core #(.CAPACITY(CAPACITY)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   mark_sweep_slab_allocator_checker #(.CAPACITY(CAPACITY)) checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   function automatic int gap_len();
      int p;
      p = $urandom_range(99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 4);
   endfunction

   // Receiver: random stalls, plus a long hold when requested
   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
         end else if (cycle_count % 3000 < 1500) begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end else begin
            rsp_stall <= (gap_len() != 0);
            @(negedge clock);
         end
      end
   end

   // Offer one transaction and wait until it is taken
   task automatic send_cmd(logic [2:0] op, logic [9:0] slot, bit no_gap = 0);
      int g;
      g = no_gap ? 0 : gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{command: op, slot_index: slot};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (1100) @(negedge clock);
   endtask

   task automatic write_capacity(logic [10:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [9:0] pick_slot(int hi);
      if ($urandom_range(9) == 0) return 10'($urandom);
      return 10'($urandom_range(hi < 1 ? 0 : hi - 1));
   endfunction

   // Random well-formed collection rounds with some noise
   task automatic random_phase(int n, int span);
      int   k;
      logic [2:0] op;
      int   p;
      for (k = 0; k < n; k++) begin
         p = $urandom_range(99);
         if (p < 40) op = msa_pkg::CMD_ALLOC;
         else if (p < 60) op = msa_pkg::CMD_FREE;
         else if (p < 85) op = msa_pkg::CMD_MARK;
         else if (p < 91) op = msa_pkg::CMD_START;
         else if (p < 96) op = msa_pkg::CMD_SWEEP;
         else op = 3'($urandom_range(7, 5));
         send_cmd(op, pick_slot(span));
      end
   endtask

   initial begin
      hold_rsp = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed: full slab at small capacity, errors, marks, sweeps
      write_capacity(11'd2);
      send_cmd(msa_pkg::CMD_ALLOC, 10'd0);
      send_cmd(msa_pkg::CMD_ALLOC, 10'd0);
      send_cmd(msa_pkg::CMD_ALLOC, 10'd0);
      send_cmd(msa_pkg::CMD_FREE, 10'd1023);
      send_cmd(msa_pkg::CMD_FREE, 10'd1);
      send_cmd(msa_pkg::CMD_FREE, 10'd1);
      send_cmd(msa_pkg::CMD_MARK, 10'd1);
      send_cmd(msa_pkg::CMD_MARK, 10'd1);
      send_cmd(msa_pkg::CMD_MARK, 10'd1023);
      send_cmd(msa_pkg::CMD_SWEEP, 10'd0);
      send_cmd(msa_pkg::CMD_START, 10'd0);
      send_cmd(msa_pkg::CMD_START, 10'd0);
      send_cmd(msa_pkg::CMD_ALLOC, 10'd0);
      send_cmd(msa_pkg::CMD_SWEEP, 10'd0);
      send_cmd(msa_pkg::CMD_SWEEP, 10'd0);
      send_cmd(3'd7, 10'h2AA);
      send_cmd(3'd5, 10'h155);
      drain();
      write_capacity(11'd0);
      send_cmd(msa_pkg::CMD_ALLOC, 10'd0);
      drain();
      write_capacity(11'd2047);
      send_cmd(msa_pkg::CMD_ALLOC, 10'd0);
      send_cmd(msa_pkg::CMD_ALLOC, 10'd0);
      drain();
      write_capacity(11'd1);
      send_cmd(msa_pkg::CMD_ALLOC, 10'd0);
      send_cmd(msa_pkg::CMD_FREE, 10'd0);
      send_cmd(msa_pkg::CMD_ALLOC, 10'd0);
      drain();

      // Pressure: receiver holds off while sender keeps offering
      write_capacity(11'd64);
      fork
         random_phase(40, 64);
         begin
            hold_rsp = 1'b1;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
      join
      drain();

      // Random phases over several capacities
      write_capacity(11'd32);
      random_phase(120, 32);
      drain();
      write_capacity(11'd1024);
      for (int j = 0; j < 150; j++) send_cmd(msa_pkg::CMD_ALLOC, 10'd0, 1);
      random_phase(60, 1024);
      send_cmd(msa_pkg::CMD_START, 10'd0);
      send_cmd(msa_pkg::CMD_MARK, 10'd100);
      send_cmd(msa_pkg::CMD_SWEEP, 10'd0);
      drain();
      write_capacity(11'd5);
      random_phase(100, 8);
      drain();
      write_capacity(11'd200);
      random_phase(100, 200);
      drain();

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
